// ===== design/wfse_pkg.sv =====
// Shared widths, register indexes and case codes for the wall-follow speed error block.
package wfse_pkg;

   localparam int SENSOR_W   = 12;
   localparam int SPEED_W    = 12;
   localparam int ERROR_W    = 14;
   localparam int CORR_W     = 9;
   localparam int COUNT_W    = 16;
   localparam int SETTLE_W   = 15;
   localparam int DIV_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // request tdata: six 12-bit fields, 72 bits
   localparam int REQ_DATA_W = 72;
   // response tdata: 14 + 14 + 9 = 37 bits, padded to 40
   localparam int RSP_FIELD_W = 2 * ERROR_W + CORR_W;
   localparam int RSP_DATA_W  = 40;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_DETECT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_DETECT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_CENTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIVISOR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CORR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE       = 3'd6;

   // wall cases
   localparam logic [1:0] CASE_NONE  = 2'd0;
   localparam logic [1:0] CASE_BOTH  = 2'd1;
   localparam logic [1:0] CASE_LEFT  = 2'd2;
   localparam logic [1:0] CASE_RIGHT = 2'd3;

   // single-wall acceptance margins below the centre level
   localparam logic signed [12:0] LEFT_MARGIN  = 13'sd80;
   localparam logic signed [12:0] RIGHT_MARGIN = 13'sd60;

endpackage

// ===== design/wall_follow_speed_error_top.sv =====
// Wall-follow speed error block: case tracking, serial divider and result register.
//
// Usage: one control tick is one request on the req_ channel (sensor samples,
// target and measured wheel speeds in req_tdata, start-of-move flag in
// req_tuser). Each request yields exactly one response on the rsp_ channel
// carrying both wheel speed errors and the applied wall correction.
// A tick that needs a wall correction runs the shared restoring divider,
// one quotient bit per cycle over 12 steps in ST_DIV, then goes to ST_FIN,
// which loads the response register; a tick without correction goes from
// ST_IDLE straight to ST_FIN. The sequencer takes no new tick until it has
// moved the last result into the response register and is back in ST_IDLE;
// req_tready is high only while the sequencer is idle.
// The response register parts the two sides: a new request is taken while the
// previous response still waits; if the receiver stalls, the next result is
// held in the sequencer until the response register frees up.
// Configuration writes on csr_ are always accepted (csr_ready is tied high); write them
// only while no tick is in flight. Unknown indexes are dropped.
// Reset (synchronous, active high) restores the register defaults, clears the
// wall case and settle counter, and empties the response register.
module wall_follow_speed_error_top (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, low bit up: left_sensor, right_sensor, left_target,
   // right_target, left_measured, right_measured (12 bits each)
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wfse_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: move_start
   input  logic                               req_tuser,
   // rsp_tdata, low bit up: left_error (14), right_error (14),
   // wall_correction (9), three zero pad bits
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wfse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wfse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wfse_pkg::CSR_DATA_W-1:0]    csr_data
);
   import wfse_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam logic [3:0] DIV_STEPS_M1 = 4'd11;

   // configuration registers
   logic [SENSOR_W-1:0] left_detect_ff, right_detect_ff;
   logic [SENSOR_W-1:0] left_center_ff, right_center_ff;
   logic [DIV_W-1:0]    divisor_ff, max_corr_ff;
   logic [SETTLE_W-1:0] settle_ticks_ff;

   // tracking state
   logic [1:0]          wall_case_ff, wall_case_in;
   logic [COUNT_W-1:0]  settle_count_ff, settle_count_in;

   // sequencer and divider
   logic [1:0]          state_ff;
   logic [3:0]          iter_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [SENSOR_W-1:0] quo_ff;
   logic                neg_ff;
   logic signed [12:0]  ldiff_ff, rdiff_ff;

   // response register
   logic                   rsp_valid_ff;
   logic [RSP_FIELD_W-1:0] rsp_data_ff;

   // request field unpacking
   logic [SENSOR_W-1:0]       ls, rs;
   logic signed [SPEED_W-1:0] lt, rt, lm, rm;
   logic                      start;

   assign ls    = req_tdata[11:0];
   assign rs    = req_tdata[23:12];
   assign lt    = req_tdata[35:24];
   assign rt    = req_tdata[47:36];
   assign lm    = req_tdata[59:48];
   assign rm    = req_tdata[71:60];
   assign start = req_tuser;

   logic req_fire, rsp_fire, load_rsp;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign load_rsp   = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   logic [DIV_W-1:0] div_eff;
   assign div_eff = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;

   // case decision for the accepted tick
   logic signed [12:0]  loff, roff;
   logic                need_div, use_right;
   logic [SENSOR_W-1:0] dividend;
   logic                dividend_neg;

   assign loff = 13'(ls) - 13'(left_center_ff);
   assign roff = 13'(rs) - 13'(right_center_ff);

   always_comb begin
      logic [1:0]         case_cur, seen;
      logic [COUNT_W-1:0] cnt_cur, cnt_base;
      logic               lw, rw;
      logic signed [12:0] off;

      case_cur = start ? CASE_NONE : wall_case_ff;
      cnt_cur  = start ? '0 : settle_count_ff;
      lw       = ls > left_detect_ff;
      rw       = rs > right_detect_ff;
      seen     = (lw && rw) ? CASE_BOTH : (lw ? CASE_LEFT : (rw ? CASE_RIGHT : CASE_NONE));
      cnt_base = cnt_cur;
      off      = '0;

      wall_case_in    = case_cur;
      settle_count_in = cnt_cur;
      need_div        = 1'b0;
      use_right       = 1'b0;

      if (lt == rt) begin
         if (seen == CASE_NONE) begin
            settle_count_in = '0;
         end else begin
            if (seen != case_cur) begin
               cnt_base     = '0;
               wall_case_in = seen;
            end
            if (cnt_base > COUNT_W'(settle_ticks_ff)) begin
               settle_count_in = cnt_base;
               if (seen == CASE_BOTH && loff > 13'sd0) begin
                  need_div = 1'b1;
               end else if (seen == CASE_BOTH && roff > 13'sd0) begin
                  need_div  = 1'b1;
                  use_right = 1'b1;
               end else if (seen == CASE_LEFT && loff > -LEFT_MARGIN) begin
                  need_div = 1'b1;
               end else if (seen == CASE_RIGHT && roff > -RIGHT_MARGIN) begin
                  need_div  = 1'b1;
                  use_right = 1'b1;
               end else begin
                  settle_count_in = '0;
               end
            end else begin
               settle_count_in = cnt_base + COUNT_W'(1);
            end
         end
      end

      off          = use_right ? roff : loff;
      dividend     = off[12] ? SENSOR_W'(-off) : SENSOR_W'(off);
      dividend_neg = off[12] ^ use_right;
   end

   // one restoring division step
   logic [DIV_W:0]   div_shift;
   logic             div_bit;
   logic [DIV_W-1:0] div_rem;

   assign div_shift = {rem_ff, quo_ff[SENSOR_W-1]};
   assign div_bit   = div_shift >= {1'b0, div_eff};
   assign div_rem   = div_bit ? DIV_W'(div_shift - {1'b0, div_eff}) : div_shift[DIV_W-1:0];

   // clamp, sign and final error sums
   logic [DIV_W-1:0]         corr_mag;
   logic [CORR_W-1:0]        corr;
   logic [ERROR_W-1:0]       lerr, rerr;

   assign corr_mag = (quo_ff > SENSOR_W'(max_corr_ff)) ? max_corr_ff : quo_ff[DIV_W-1:0];
   assign corr     = neg_ff ? CORR_W'(-{1'b0, corr_mag}) : {1'b0, corr_mag};
   assign lerr     = {ldiff_ff[12], ldiff_ff} + {{(ERROR_W-CORR_W){corr[CORR_W-1]}}, corr};
   assign rerr     = {rdiff_ff[12], rdiff_ff} - {{(ERROR_W-CORR_W){corr[CORR_W-1]}}, corr};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_FIELD_W)'(0), rsp_data_ff};
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_detect_ff  <= SENSOR_W'(500);
         right_detect_ff <= SENSOR_W'(500);
         left_center_ff  <= SENSOR_W'(1500);
         right_center_ff <= SENSOR_W'(1500);
         divisor_ff      <= DIV_W'(8);
         max_corr_ff     <= DIV_W'(30);
         settle_ticks_ff <= SETTLE_W'(200);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LEFT_DETECT:  left_detect_ff  <= csr_data[SENSOR_W-1:0];
            REG_RIGHT_DETECT: right_detect_ff <= csr_data[SENSOR_W-1:0];
            REG_LEFT_CENTER:  left_center_ff  <= csr_data[SENSOR_W-1:0];
            REG_RIGHT_CENTER: right_center_ff <= csr_data[SENSOR_W-1:0];
            REG_DIVISOR:      divisor_ff      <= csr_data[DIV_W-1:0];
            REG_MAX_CORR:     max_corr_ff     <= csr_data[DIV_W-1:0];
            REG_SETTLE:       settle_ticks_ff <= csr_data[SETTLE_W-1:0];
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   // sequencer and tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         wall_case_ff    <= CASE_NONE;
         settle_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  wall_case_ff    <= wall_case_in;
                  settle_count_ff <= settle_count_in;
                  state_ff        <= need_div ? ST_DIV : ST_FIN;
               end
            end
            ST_DIV: begin
               if (iter_ff == '0) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (load_rsp) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         iter_ff  <= DIV_STEPS_M1;
         rem_ff   <= '0;
         quo_ff   <= need_div ? dividend : '0;
         neg_ff   <= need_div ? dividend_neg : 1'b0;
         // sign-extend both speeds by one bit before the subtraction
         ldiff_ff <= {lt[11], lt} - {lm[11], lm};
         rdiff_ff <= {rt[11], rt} - {rm[11], rm};
      end else if (state_ff == ST_DIV) begin
         iter_ff <= iter_ff - 4'd1;
         rem_ff  <= div_rem;
         quo_ff  <= {quo_ff[SENSOR_W-2:0], div_bit};
      end
      if (load_rsp) begin
         rsp_data_ff <= {corr, rerr, lerr};
      end
   end

   // checks
   logic [CORR_W-1:0] rsp_corr, rsp_corr_abs;
   assign rsp_corr     = rsp_data_ff[RSP_FIELD_W-1:2*ERROR_W];
   assign rsp_corr_abs = rsp_corr[CORR_W-1] ? CORR_W'(-rsp_corr) : rsp_corr;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while a tick was in flight");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_eff))
      else $error("divider remainder reached the divisor");

   a_corr_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_corr_abs <= {1'b0, max_corr_ff}))
      else $error("wall correction beyond clamp");

   a_no_case_no_count: assert property (@(posedge clock) disable iff (reset)
      (wall_case_ff == CASE_NONE) |-> (settle_count_ff == '0))
      else $error("settle counter running without a wall case");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && iter_ff == '0) |=> (state_ff == ST_FIN))
      else $error("divider did not hand over after its last step");

endmodule

// ===== bench/tb_wall_follow_speed_error_top.sv =====
// Self-checking bench for the wall-follow speed error block: directed and random control ticks.
import wfse_pkg::*;

typedef struct {
   logic signed [ERROR_W-1:0] left_error;
   logic signed [ERROR_W-1:0] right_error;
   logic signed [CORR_W-1:0]  wall_correction;
} speed_error_type;

class speed_error_board;
   int              left_detect;
   int              right_detect;
   int              left_centre;
   int              right_centre;
   int              divisor;
   int              max_corr;
   int              settle_ticks;
   logic [1:0]      wall_case;
   int              settle_count;
   speed_error_type expected_errors[$];
   int              errors;
   int              checked;
   int              corrected;

   function new();
      left_detect  = 500;
      right_detect = 500;
      left_centre  = 1500;
      right_centre = 1500;
      divisor      = 8;
      max_corr     = 30;
      settle_ticks = 200;
      wall_case    = CASE_NONE;
      settle_count = 0;
      errors       = 0;
      checked      = 0;
      corrected    = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_LEFT_DETECT:  left_detect  = data[SENSOR_W-1:0];
         REG_RIGHT_DETECT: right_detect = data[SENSOR_W-1:0];
         REG_LEFT_CENTER:  left_centre  = data[SENSOR_W-1:0];
         REG_RIGHT_CENTER: right_centre = data[SENSOR_W-1:0];
         REG_DIVISOR:      divisor      = data[DIV_W-1:0];
         REG_MAX_CORR:     max_corr     = data[7:0];
         REG_SETTLE:       settle_ticks = data[SETTLE_W-1:0];
         default: ;
      endcase
   endfunction

   // divide toward zero, then clamp to the correction limit
   function int scale_offset(int offset);
      int d;
      int q;
      d = (divisor == 0) ? 1 : divisor;
      q = offset / d;
      if (q > max_corr) q = max_corr;
      if (q < -max_corr) q = -max_corr;
      return q;
   endfunction

   function void note_request(logic [REQ_DATA_W-1:0] d, logic start);
      int              ls, rs, lt, rt, lm, rm, w, sum;
      logic [1:0]      seen;
      speed_error_type e;
      ls = d[11:0];
      rs = d[23:12];
      lt = $signed(d[35:24]);
      rt = $signed(d[47:36]);
      lm = $signed(d[59:48]);
      rm = $signed(d[71:60]);
      w  = 0;
      if (start) begin
         wall_case    = CASE_NONE;
         settle_count = 0;
      end
      if (lt == rt) begin
         if (ls > left_detect && rs > right_detect) seen = CASE_BOTH;
         else if (ls > left_detect) seen = CASE_LEFT;
         else if (rs > right_detect) seen = CASE_RIGHT;
         else seen = CASE_NONE;
         if (seen == CASE_NONE) begin
            settle_count = 0;
         end else begin
            if (seen != wall_case) begin
               settle_count = 0;
               wall_case    = seen;
            end
            if (settle_count <= settle_ticks)
               settle_count = (settle_count + 1) & 16'hFFFF;
            else if (seen == CASE_BOTH && ls > left_centre)
               w = scale_offset(ls - left_centre);
            else if (seen == CASE_BOTH && rs > right_centre)
               w = -scale_offset(rs - right_centre);
            else if (seen == CASE_LEFT && ls > left_centre - int'(LEFT_MARGIN))
               w = scale_offset(ls - left_centre);
            else if (seen == CASE_RIGHT && rs > right_centre - int'(RIGHT_MARGIN))
               w = -scale_offset(rs - right_centre);
            else
               settle_count = 0;
         end
      end
      if (w != 0) corrected++;
      sum = lt - lm + w;
      e.left_error = sum[ERROR_W-1:0];
      sum = rt - rm - w;
      e.right_error = sum[ERROR_W-1:0];
      e.wall_correction = w[CORR_W-1:0];
      expected_errors.push_back(e);
   endfunction

   function void compare_field(string name, logic signed [ERROR_W-1:0] want,
                               logic signed [ERROR_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function void check_response(logic [RSP_DATA_W-1:0] d);
      speed_error_type want;
      speed_error_type got;
      got.left_error      = d[ERROR_W-1:0];
      got.right_error     = d[2*ERROR_W-1:ERROR_W];
      got.wall_correction = d[RSP_FIELD_W-1:2*ERROR_W];
      if (expected_errors.size() == 0) begin
         errors++;
         $display("%0t: response with nothing outstanding, expected none, actual %0d %0d %0d",
                  $time, got.left_error, got.right_error, got.wall_correction);
         return;
      end
      want = expected_errors.pop_front();
      checked++;
      compare_field("left_error", want.left_error, got.left_error);
      compare_field("right_error", want.right_error, got.right_error);
      compare_field("wall_correction", want.wall_correction, got.wall_correction);
   endfunction
endclass

module tb_wall_follow_speed_error_top;

   // index with no register behind it; writes to it must leave everything alone
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   // quiet cycles allowed: far above a full divide plus the longest gaps on both sides
   localparam int QUIET_LIMIT   = 2000;
   // cycles to linger once nothing is outstanding, a little above the divider latency
   localparam int TAIL_CYCLES   = 20;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_TICKS   = 110;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   speed_error_board board;
   int               quiet_cycles = 0;
   int               settings_used = 0;
   bit               steady_sender = 1'b0;
   // register values of the current phase; random sensors are biased around the centres
   int               set_ld, set_rd, set_lc, set_rc, set_dv, set_mx, set_st;

   wall_follow_speed_error_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe all three channels at the clock edge. Check responses before noting the
   // request of the same edge, so a response is never matched against its own request.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) board.check_response(rsp_tdata);
         if (req_tvalid && req_tready === 1'b1) board.note_request(req_tdata, req_tuser);
         if (csr_valid && csr_ready === 1'b1) board.write_reg(csr_index, csr_data);
         if ((rsp_tvalid === 1'b1 && rsp_tready) || (req_tvalid && req_tready === 1'b1) ||
             (csr_valid && csr_ready === 1'b1))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: give up when nothing has moved on any channel for too long.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: mostly short stalls, now and then a long one, and long stretches
   // of steady ready so back-to-back responses are seen as well.
   initial begin
      int r;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         r = $urandom_range(0, 99);
         repeat (r < 20 ? $urandom_range(40, 200) : $urandom_range(1, 8)) @(posedge clock);
         rsp_tready <= 1'b0;
         r = $urandom_range(0, 99);
         repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(20, 60)) @(posedge clock);
      end
   end

   function automatic int clip_sensor(int v);
      if (v < 0) return 0;
      if (v > 4095) return 4095;
      return v;
   endfunction

   // Present one tick, hold it until taken, then idle the sender for a random gap.
   // Valid is left high when no gap follows, so the next request goes back to back.
   // Each field keeps its low 12 bits.
   task automatic send_tick(input int ls, input int rs, input int lt, input int rt,
                            input int lm, input int rm, input logic st);
      int r;
      int gap;
      req_tdata  <= {12'(rm), 12'(lm), 12'(rt), 12'(lt), 12'(rs), 12'(ls)};
      req_tuser  <= st;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      r = $urandom_range(0, 99);
      if (steady_sender || r < 50) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every expected response is back, then linger a little.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected_errors.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // One register write; bits above the register's width carry random junk.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value, input int width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] noise;
      mask  = CSR_DATA_W'((1 << width) - 1);
      noise = CSR_DATA_W'($urandom);
      csr_index <= idx;
      csr_data  <= (CSR_DATA_W'(value) & mask) | (noise & ~mask);
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic apply_settings();
      write_reg(REG_LEFT_DETECT, set_ld, SENSOR_W);
      write_reg(REG_RIGHT_DETECT, set_rd, SENSOR_W);
      write_reg(REG_UNUSED, $urandom, CSR_DATA_W);
      write_reg(REG_LEFT_CENTER, set_lc, SENSOR_W);
      write_reg(REG_RIGHT_CENTER, set_rc, SENSOR_W);
      write_reg(REG_DIVISOR, set_dv, DIV_W);
      write_reg(REG_MAX_CORR, set_mx, 8);
      write_reg(REG_SETTLE, set_st, SETTLE_W);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int ls, rs, lt, rt, lm, rm, speed, scenario, run_len, sent, j;
      bit st;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      board      = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first: start a move against two walls at full speed error,
      // then unequal targets with the widest spread, then saturated sensors.
      send_tick(2000, 2000, 2047, 2047, -2048, -2048, 1'b1);
      send_tick(2000, 2000, -2048, 2047, 2047, -2048, 1'b0);
      send_tick(4095, 4095, 0, 0, 0, 0, 1'b0);

      // Short settle so every case reaches its correction within a few ticks.
      wait_drained();
      set_ld = 500; set_rd = 500; set_lc = 1500; set_rc = 1500;
      set_dv = 8; set_mx = 30; set_st = 2;
      apply_settings();
      // both walls: settle, then left nearer, clamp, right nearer, and centred
      send_tick(2000, 2000, 0, 0, 0, 0, 1'b1);
      send_tick(2000, 2000, 0, 0, 0, 0, 1'b0);
      send_tick(2000, 2000, 0, 0, 0, 0, 1'b0);
      send_tick(1600, 2000, 0, 0, 0, 0, 1'b0);
      send_tick(4095, 2000, 0, 0, 0, 0, 1'b0);
      send_tick(1400, 1700, 0, 0, 0, 0, 1'b0);
      send_tick(1500, 1500, 0, 0, 0, 0, 1'b0);
      // left wall only: settle, negative offset truncated toward zero, exactly at the margin edge
      send_tick(1450, 0, 0, 0, 0, 0, 1'b0);
      send_tick(1450, 0, 0, 0, 0, 0, 1'b0);
      send_tick(1450, 0, 0, 0, 0, 0, 1'b0);
      send_tick(1430, 0, 0, 0, 0, 0, 1'b0);
      send_tick(1420, 0, 0, 0, 0, 0, 1'b0);
      // right wall only: settle, inside the margin, then clamped the other way
      send_tick(0, 1460, 0, 0, 0, 0, 1'b0);
      send_tick(0, 1460, 0, 0, 0, 0, 1'b0);
      send_tick(0, 1460, 0, 0, 0, 0, 1'b0);
      send_tick(0, 1445, 0, 0, 0, 0, 1'b0);
      send_tick(0, 4095, 0, 0, 0, 0, 1'b0);
      // readings exactly at the detect level see no wall: counter cleared, case kept
      send_tick(500, 500, 0, 0, 0, 0, 1'b0);
      send_tick(0, 2000, -2048, -2048, 2047, 2047, 1'b0);
      // start of move mid-case, then sensors just above the detect level
      send_tick(0, 4095, 100, 100, 90, 110, 1'b1);
      send_tick(501, 501, 100, 100, 90, 110, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         case (p)
            0: begin
               set_ld = 500; set_rd = 500; set_lc = 1500; set_rc = 1500;
               set_dv = 8; set_mx = 30; set_st = 5;
            end
            1: begin
               // zero divisor behaves as one; widest clamp, shortest settle
               set_ld = 0; set_rd = 0; set_lc = 0; set_rc = 0;
               set_dv = 0; set_mx = 255; set_st = 0;
            end
            2: begin
               // nothing can exceed the detect levels; longest settle, no clamp room
               set_ld = 4095; set_rd = 4095; set_lc = 4095; set_rc = 4095;
               set_dv = 255; set_mx = 0; set_st = 32767;
            end
            3: begin
               set_ld = 300; set_rd = 700; set_lc = 2000; set_rc = 1200;
               set_dv = 1; set_mx = 255; set_st = 1;
            end
            default: begin
               set_ld = $urandom_range(0, 1000);
               set_rd = $urandom_range(0, 1000);
               set_lc = $urandom_range(800, 3500);
               set_rc = $urandom_range(800, 3500);
               set_dv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                    : $urandom_range(1, 16);
               set_mx = $urandom_range(0, 255);
               set_st = $urandom_range(0, 30);
            end
         endcase
         apply_settings();
         steady_sender = ($urandom_range(0, 3) == 0);

         // Runs of ticks that hold one wall picture long enough to settle, with
         // sensors scattered around the centre levels; a fifth of runs are pure noise.
         sent = 0;
         while (sent < PHASE_TICKS) begin
            run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(3, 25);
            scenario = $urandom_range(0, 9);
            speed    = $urandom_range(0, 4095);
            for (int k = 0; k < run_len && sent < PHASE_TICKS; k++) begin
               j  = $urandom_range(0, 500);
               ls = (scenario <= 4) ? clip_sensor(set_lc + j - 250) : $urandom_range(0, 400);
               j  = $urandom_range(0, 500);
               rs = (scenario <= 2 || scenario == 5 || scenario == 6)
                    ? clip_sensor(set_rc + j - 250) : $urandom_range(0, 400);
               lt = speed;
               rt = speed;
               if ($urandom_range(0, 9) == 0) rt = speed + $urandom_range(1, 4095);
               j  = $urandom_range(0, 64);
               lm = speed + j - 32;
               j  = $urandom_range(0, 64);
               rm = speed + j - 32;
               st = (k == 0 && $urandom_range(0, 2) == 0) || ($urandom_range(0, 49) == 0);
               if (scenario >= 8) begin
                  ls = $urandom; rs = $urandom; lt = $urandom;
                  rt = $urandom; lm = $urandom; rm = $urandom;
                  st = 1'($urandom_range(0, 1));
               end
               send_tick(ls, rs, lt, rt, lm, rm, st);
               sent++;
               // now and then let the block run completely dry mid-phase
               if ($urandom_range(0, 299) == 0) wait_drained();
            end
         end
      end

      wait_drained();
      $display("Summary: %0d ticks checked under %0d register settings, %0d of them corrected.",
               board.checked, settings_used, board.corrected);
      if (board.errors == 0 && board.expected_errors.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d responses missing", board.errors,
                  board.expected_errors.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
